@@ hdl/stt_pkg.sv @@
// stt_pkg: shared types and constants of the source text tokenizer.
// Used by stt_front, stt_back and source_text_tokenizer; no dependencies.
`timescale 1ns / 1ps

package stt_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int QDEPTH = 4;

	localparam logic [1:0] KIND_WORD   = 2'd0;
	localparam logic [1:0] KIND_NUMBER = 2'd1;
	localparam logic [1:0] KIND_STRING = 2'd2;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_NEWLINE   = 2'd1;
	localparam logic [1:0] ERR_UNTERM    = 2'd2;
	localparam logic [1:0] ERR_ESC_RANGE = 2'd3;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;

	localparam logic [8:0] ESC_LIMIT = 9'd256;

	typedef struct packed {
		logic [7:0]  token_byte;
		logic        has_byte;
		logic [1:0]  token_kind;
		logic        token_first;
		logic        token_last;
		logic [1:0]  error_code;
		logic [15:0] token_line;
		logic [15:0] start_column;
	} item_t;

	typedef struct packed {
		logic [1:0] cnt;
		item_t      item0;
		item_t      item1;
	} wr_t;

endpackage

@@ hdl/stt_front.sv @@
// stt_front: accepts source bytes, runs the scan state machine and
// produces up to two result items per byte. Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_front #(
	parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [7:0]   source_byte,
	input  logic         end_of_source,
	input  logic         room,
	output stt_pkg::wr_t wr
);
	import stt_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE, M_WORD, M_STR_OPEN, M_STR, M_STR_ESC, M_STR_NUM, M_ML_LEAD,
		M_ML, M_ML_STAR, M_ML_ESC, M_ML_NUM, M_ML_INDENT, M_HALT
	} mode_t;

	typedef enum logic [1:0] {OP_PUSH, OP_CLOSE, OP_FAIL} op_code_t;

	typedef struct packed {
		op_code_t   code;
		logic [7:0] arg;
	} op_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       vld;
		logic [1:0] cnt;
	} tok_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       has;
		logic       first;
		logic       last;
		logic [1:0] err;
	} em_t;

	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	function automatic logic is_space(input logic [7:0] c);
		return c inside {CH_SP, CH_TAB, CH_LF};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_0:CH_9]};
	endfunction

	function automatic logic [7:0] escape_char(input logic [7:0] c);
		case (c)
			CH_N:    return CH_LF;
			CH_R:    return CH_CR;
			CH_T:    return CH_TAB;
			default: return c;
		endcase
	endfunction

	function automatic logic [15:0] cap16(input logic [POSITION_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'd65535) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic op_t mk(input op_code_t code, input logic [7:0] arg);
		op_t o;
		o.code = code;
		o.arg  = arg;
		return o;
	endfunction

	mode_t                    mode_q, mode_n;
	tok_t                     tok_q, t;
	logic [8:0]               esc_q, esc_n;
	logic [1:0]               kind_q, kind_n, em_kind;
	logic [POSITION_BITS-1:0] indent_q, indent_n;
	logic [POSITION_BITS-1:0] line_q, line_n, col_q, col_n;
	logic [POSITION_BITS-1:0] tl_q, tl_n, tc_q, tc_n;
	logic                     acc;
	logic                     run_str, run_ml;
	logic [11:0]              dig;
	logic [1:0]               nop, ne;
	op_t                      op [2];
	em_t                      em [2];
	logic [7:0]               c;

	assign c        = source_byte;
	assign in_stall = !room;
	assign acc      = in_valid && room;
	assign dig      = 12'(esc_q) * 12'd10 + 12'(c[3:0]);

	always_comb begin
		mode_n   = mode_q;
		t        = tok_q;
		esc_n    = esc_q;
		kind_n   = kind_q;
		indent_n = indent_q;
		line_n   = line_q;
		col_n    = col_q;
		tl_n     = tl_q;
		tc_n     = tc_q;
		run_str  = 1'b0;
		run_ml   = 1'b0;
		nop      = 2'd0;
		ne       = 2'd0;
		op[0]    = '0;
		op[1]    = '0;
		em[0]    = '0;
		em[1]    = '0;

		if (end_of_source) begin
			case (mode_q)
				M_WORD, M_ML_LEAD, M_ML, M_ML_ESC, M_ML_INDENT: begin
					op[0] = mk(OP_CLOSE, 8'd0);
					nop = 2'd1;
				end
				M_STR_OPEN, M_STR, M_STR_ESC: begin
					op[0] = mk(OP_FAIL, 8'(ERR_UNTERM));
					nop = 2'd1;
				end
				M_STR_NUM: begin
					op[0] = mk(OP_FAIL, (esc_q >= ESC_LIMIT) ? 8'(ERR_ESC_RANGE) : 8'(ERR_UNTERM));
					nop = 2'd1;
				end
				M_ML_STAR: begin
					op[0] = mk(OP_PUSH, CH_STAR);
					op[1] = mk(OP_CLOSE, 8'd0);
					nop = 2'd2;
				end
				M_ML_NUM: begin
					if (esc_q >= ESC_LIMIT) begin
						op[0] = mk(OP_FAIL, 8'(ERR_ESC_RANGE));
						nop = 2'd1;
					end else begin
						op[0] = mk(OP_PUSH, esc_q[7:0]);
						op[1] = mk(OP_CLOSE, 8'd0);
						nop = 2'd2;
					end
				end
				default: ;
			endcase
		end else begin
			case (mode_q)
				M_IDLE: begin
					if (!is_space(c)) begin
						tl_n  = line_q;
						tc_n  = col_q;
						t     = '0;
						esc_n = '0;
						if (c == CH_QUOTE) begin
							kind_n = KIND_STRING;
							mode_n = M_STR_OPEN;
						end else begin
							kind_n = is_digit(c) ? KIND_NUMBER : KIND_WORD;
							t.ch   = c;
							t.vld  = 1'b1;
							t.cnt  = 2'd1;
							mode_n = M_WORD;
						end
					end
				end
				M_WORD: begin
					if (is_space(c)) begin
						op[0] = mk(OP_CLOSE, 8'd0);
						nop = 2'd1;
					end else begin
						if (tok_q.cnt == 2'd1 && (tok_q.ch == CH_MINUS || tok_q.ch == CH_PLUS)
								&& is_digit(c))
							kind_n = KIND_NUMBER;
						op[0] = mk(OP_PUSH, c);
						nop = 2'd1;
					end
				end
				M_STR_OPEN: begin
					if (c == CH_STAR) begin
						mode_n = M_ML_LEAD;
					end else begin
						mode_n  = M_STR;
						run_str = 1'b1;
					end
				end
				M_STR: run_str = 1'b1;
				M_STR_ESC, M_ML_ESC: begin
					if (c == CH_0) begin
						esc_n  = '0;
						mode_n = (mode_q == M_STR_ESC) ? M_STR_NUM : M_ML_NUM;
					end else begin
						op[0]  = mk(OP_PUSH, escape_char(c));
						nop    = 2'd1;
						mode_n = (mode_q == M_STR_ESC) ? M_STR : M_ML;
					end
				end
				M_STR_NUM, M_ML_NUM: begin
					if (is_digit(c)) begin
						esc_n = (dig > 12'(ESC_LIMIT)) ? ESC_LIMIT : dig[8:0];
					end else if (esc_q >= ESC_LIMIT) begin
						op[0] = mk(OP_FAIL, 8'(ERR_ESC_RANGE));
						nop = 2'd1;
					end else begin
						op[0] = mk(OP_PUSH, esc_q[7:0]);
						nop = 2'd1;
						if (mode_q == M_STR_NUM) begin
							mode_n  = M_STR;
							run_str = 1'b1;
						end else begin
							mode_n = M_ML;
							run_ml = 1'b1;
						end
					end
				end
				M_ML_LEAD: begin
					if (!is_space(c)) begin
						indent_n = col_q;
						mode_n   = M_ML;
						run_ml   = 1'b1;
					end
				end
				M_ML: run_ml = 1'b1;
				M_ML_STAR: begin
					if (c == CH_QUOTE) begin
						op[0] = mk(OP_CLOSE, 8'd0);
						nop = 2'd1;
					end else begin
						op[0]  = mk(OP_PUSH, CH_STAR);
						nop    = 2'd1;
						mode_n = M_ML;
						run_ml = 1'b1;
					end
				end
				M_ML_INDENT: begin
					if (is_space(c) && col_q < indent_q) begin
						if (c == CH_LF) begin
							op[0] = mk(OP_PUSH, CH_LF);
							nop = 2'd1;
						end
					end else begin
						mode_n = M_ML;
						run_ml = 1'b1;
					end
				end
				default: ;
			endcase

			if (run_str) begin
				if (c == CH_QUOTE) begin
					op[nop[0]] = mk(OP_CLOSE, 8'd0);
					nop = nop + 2'd1;
				end else if (c == CH_LF) begin
					op[nop[0]] = mk(OP_FAIL, 8'(ERR_NEWLINE));
					nop = nop + 2'd1;
				end else if (c == CH_BSL) begin
					mode_n = M_STR_ESC;
				end else begin
					op[nop[0]] = mk(OP_PUSH, c);
					nop = nop + 2'd1;
				end
			end
			if (run_ml) begin
				if (c == CH_STAR) begin
					mode_n = M_ML_STAR;
				end else if (c == CH_BSL) begin
					mode_n = M_ML_ESC;
				end else begin
					op[nop[0]] = mk(OP_PUSH, c);
					nop = nop + 2'd1;
					if (c == CH_LF)
						mode_n = M_ML_INDENT;
				end
			end
		end

		for (int i = 0; i < 2; i++) begin
			if (2'(i) < nop) begin
				case (op[i].code)
					OP_PUSH: begin
						if (t.vld) begin
							em[ne[0]] = '{t.ch, 1'b1, t.cnt == 2'd1, 1'b0, ERR_NONE};
							ne = ne + 2'd1;
							t.cnt = 2'd2;
						end else begin
							t.cnt = 2'd1;
						end
						t.ch  = op[i].arg;
						t.vld = 1'b1;
					end
					OP_CLOSE: begin
						if (t.vld)
							em[ne[0]] = '{t.ch, 1'b1, t.cnt == 2'd1, 1'b1, ERR_NONE};
						else
							em[ne[0]] = '{8'd0, 1'b0, 1'b1, 1'b1, ERR_NONE};
						ne     = ne + 2'd1;
						t      = '0;
						esc_n  = '0;
						mode_n = M_IDLE;
					end
					OP_FAIL: begin
						kind_n    = KIND_STRING;
						em[ne[0]] = '{8'd0, 1'b0, t.cnt < 2'd2, 1'b1, op[i].arg[1:0]};
						ne        = ne + 2'd1;
						t         = '0;
						esc_n     = '0;
						mode_n    = M_HALT;
					end
					default: ;
				endcase
			end
		end

		em_kind = kind_n;

		if (end_of_source) begin
			mode_n   = M_IDLE;
			kind_n   = KIND_WORD;
			t        = '0;
			esc_n    = '0;
			indent_n = '0;
			line_n   = POS_ONE;
			col_n    = POS_ONE;
			tl_n     = POS_ONE;
			tc_n     = POS_ONE;
		end else if (c == CH_LF) begin
			if (line_q != POS_MAX)
				line_n = line_q + POS_ONE;
			col_n = POS_ONE;
		end else if (col_q != POS_MAX) begin
			col_n = col_q + POS_ONE;
		end
	end

	always_comb begin
		wr.cnt   = acc ? ne : 2'd0;
		wr.item0 = '{em[0].ch, em[0].has, em_kind, em[0].first, em[0].last, em[0].err,
			cap16(tl_q), cap16(tc_q)};
		wr.item1 = '{em[1].ch, em[1].has, em_kind, em[1].first, em[1].last, em[1].err,
			cap16(tl_q), cap16(tc_q)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			tok_q    <= '0;
			esc_q    <= '0;
			kind_q   <= KIND_WORD;
			indent_q <= '0;
			line_q   <= POS_ONE;
			col_q    <= POS_ONE;
			tl_q     <= POS_ONE;
			tc_q     <= POS_ONE;
		end else if (acc) begin
			mode_q   <= mode_n;
			tok_q    <= t;
			esc_q    <= esc_n;
			kind_q   <= kind_n;
			indent_q <= indent_n;
			line_q   <= line_n;
			col_q    <= col_n;
			tl_q     <= tl_n;
			tc_q     <= tc_n;
		end
	end

endmodule

@@ hdl/stt_back.sv @@
// stt_back: result queue (up to two writes, one read per cycle while the output
// is not stalled) and output register. Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  stt_pkg::wr_t   wr,
	output logic           room,
	output logic           out_valid,
	input  logic           out_stall,
	output stt_pkg::item_t out_item
);
	import stt_pkg::*;

	localparam int AW = $clog2(QDEPTH);

	item_t         mem [QDEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   cnt_q;
	logic          out_valid_q;
	item_t         out_q;
	logic          pop;

	assign pop       = (cnt_q != '0) && (!out_valid_q || !out_stall);
	assign room      = cnt_q <= (AW + 1)'(QDEPTH - 2);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(wr.cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (AW + 1)'(wr.cnt) - (AW + 1)'(pop);
			if (pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.cnt != 2'd0)
			mem[wr_ptr_q] <= wr.item0;
		if (wr.cnt == 2'd2)
			mem[wr_ptr_q + 1'b1] <= wr.item1;
		if (pop)
			out_q <= mem[rd_ptr_q];
	end

endmodule

@@ hdl/source_text_tokenizer.sv @@
// Channel  | handshake            | payload
// input    | in_valid / in_stall  | source_byte, end_of_source
// output   | out_valid / out_stall| token_byte, has_byte, token_kind, token_first,
//          |                      | token_last, error_code, token_line, start_column
//
// One source byte is taken per cycle while in_stall is low; each byte yields zero
// to two result items. The output register drains one item per cycle while
// out_stall is low, from a four-entry queue; the first result of a byte is written
// to the queue and then loaded into the output register before it is valid.
// arst_n clears all control state (queue and output data are not reset); no clearing pass is needed.
// in_stall rises while fewer than two queue entries are free.
//
// Top level: stt_front feeding stt_back; depends on stt_pkg.
`timescale 1ns / 1ps

module source_text_tokenizer #(
	parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  source_byte,
	input  logic        end_of_source,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  token_byte,
	output logic        has_byte,
	output logic [1:0]  token_kind,
	output logic        token_first,
	output logic        token_last,
	output logic [1:0]  error_code,
	output logic [15:0] token_line,
	output logic [15:0] start_column
);
	import stt_pkg::*;

	wr_t   wr;
	logic  room;
	item_t item;

	stt_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.source_byte  (source_byte),
		.end_of_source(end_of_source),
		.room         (room),
		.wr           (wr)
	);

	stt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (item)
	);

	assign token_byte   = item.token_byte;
	assign has_byte     = item.has_byte;
	assign token_kind   = item.token_kind;
	assign token_first  = item.token_first;
	assign token_last   = item.token_last;
	assign error_code   = item.error_code;
	assign token_line   = item.token_line;
	assign start_column = item.start_column;

endmodule
